### rtl/hnf_pkg.sv
package hnf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ADDR_W      = 32;
    localparam int STEP_W      = $clog2(ADDR_W);
    localparam int CFG_W       = 7;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(64);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] mask;
    } in_word_t;

    typedef struct packed {
        logic status;
        logic matched;
    } out_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] mask;
    } entry_t;

endpackage

### rtl/hashed_netmask_filter_table.sv
// channel   dir   handshake            word
// in        in    in_valid / in_stall   hnf_pkg::in_word_t  (op, address, mask)
// out       out   out_valid / out_stall hnf_pkg::out_word_t (status, matched)
// cfg       in    cfg_valid / cfg_ready cfg_data: entries_in_use
//
// An item is accepted, runs through the bit-serial remainder unit over all 32 address
// bits, then probes slots from the start slot to a hit or the end of the live slots,
// and its result is then loaded into the output register.
// Table reads come from a single-port-read RAM, one slot per cycle, pipelined.
// Reset clears the slot valid flops at once; entries_in_use resets to 64.
// The input stalls while an item is at work; a stalled result holds in the
// output register and the next item is still taken.
module hashed_netmask_filter_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  hnf_pkg::in_word_t            in_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output hnf_pkg::out_word_t           out_word,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hnf_pkg::CFG_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PROBE,
        ST_DONE
    } state_t;

    state_t                          state_reg, state_next;
    hnf_pkg::in_word_t               in_reg, in_next;
    logic [hnf_pkg::ADDR_W-1:0]      shift_reg, shift_next;
    logic [hnf_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [hnf_pkg::IDX_W-1:0]       rem_reg, rem_next;
    logic [hnf_pkg::CNT_W-1:0]       issue_reg, issue_next;
    logic [hnf_pkg::IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [hnf_pkg::TABLE_DEPTH-1:0] used_reg, used_next;
    hnf_pkg::out_word_t              res_reg, res_next;
    logic                            out_valid_reg, out_valid_next;
    hnf_pkg::out_word_t              out_word_reg, out_word_next;
    logic [hnf_pkg::CFG_W-1:0]       entries_reg, entries_next;

    logic [hnf_pkg::CNT_W-1:0]       live_n;
    logic [hnf_pkg::CNT_W-1:0]       trial;
    logic [hnf_pkg::CNT_W-1:0]       trial_rem;
    logic                            slot_hit;
    logic                            in_accept;
    hnf_pkg::entry_t                 rd_entry;
    hnf_pkg::entry_t                 wr_entry;
    logic                            ram_wr_en;
    logic                            ram_rd_en;

    // slot count clamped to 1..TABLE_DEPTH
    always_comb
    begin
        if (entries_reg == '0)
        begin
            live_n = hnf_pkg::CNT_W'(1);
        end
        else if (hnf_pkg::CNT_W'(entries_reg) > hnf_pkg::CNT_W'(hnf_pkg::TABLE_DEPTH))
        begin
            live_n = hnf_pkg::CNT_W'(hnf_pkg::TABLE_DEPTH);
        end
        else
        begin
            live_n = hnf_pkg::CNT_W'(entries_reg);
        end
    end

    // restoring remainder, one address bit a cycle
    assign trial     = {rem_reg, shift_reg[hnf_pkg::ADDR_W-1]};
    assign trial_rem = (trial >= live_n) ? (trial - live_n) : trial;

    always_comb
    begin
        slot_hit = 1'b0;
        case (in_reg.op)
            hnf_pkg::OP_INSERT:
                slot_hit = !used_reg[pend_idx_reg];
            hnf_pkg::OP_REMOVE:
                slot_hit = used_reg[pend_idx_reg]
                        && rd_entry.address == in_reg.address
                        && rd_entry.mask == in_reg.mask;
            hnf_pkg::OP_LOOKUP:
                slot_hit = used_reg[pend_idx_reg]
                        && (rd_entry.address & rd_entry.mask)
                           == (in_reg.address & rd_entry.mask);
            default:
                slot_hit = 1'b0;
        endcase
        slot_hit = slot_hit && pend_valid_reg;
    end

    assign in_accept = in_valid && !in_stall;
    assign ram_rd_en = (state_reg == ST_PROBE) && !slot_hit && (issue_reg < live_n);
    assign ram_wr_en = (state_reg == ST_PROBE) && slot_hit && (in_reg.op == hnf_pkg::OP_INSERT);
    assign wr_entry  = '{address: in_reg.address, mask: in_reg.mask};

    always_comb
    begin
        state_next      = state_reg;
        in_next         = in_reg;
        shift_next      = shift_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        issue_next      = issue_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        used_next       = used_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        entries_next    = entries_reg;

        if (cfg_valid && cfg_ready)
        begin
            entries_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    in_next    = in_word;
                    shift_next = in_word.address;
                    step_next  = hnf_pkg::STEP_W'(hnf_pkg::ADDR_W - 1);
                    rem_next   = '0;
                    res_next   = '{status: 1'b0, matched: 1'b0};
                    if (in_word.op == hnf_pkg::OP_INSERT || in_word.op == hnf_pkg::OP_REMOVE
                        || in_word.op == hnf_pkg::OP_LOOKUP)
                    begin
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                rem_next   = trial_rem[hnf_pkg::IDX_W-1:0];
                shift_next = {shift_reg[hnf_pkg::ADDR_W-2:0], 1'b0};
                step_next  = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    issue_next      = {1'b0, trial_rem[hnf_pkg::IDX_W-1:0]};
                    pend_valid_next = 1'b0;
                    state_next      = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (slot_hit)
                begin
                    state_next = ST_DONE;
                    case (in_reg.op)
                        hnf_pkg::OP_INSERT: used_next[pend_idx_reg] = 1'b1;
                        hnf_pkg::OP_REMOVE: used_next[pend_idx_reg] = 1'b0;
                        hnf_pkg::OP_LOOKUP: res_next.matched = 1'b1;
                        default: ;
                    endcase
                end
                else if (issue_reg < live_n)
                begin
                    pend_idx_next   = issue_reg[hnf_pkg::IDX_W-1:0];
                    pend_valid_next = 1'b1;
                    issue_next      = issue_reg + 1'b1;
                end
                else
                begin
                    // ran off the end of the live slots
                    res_next.status = (in_reg.op == hnf_pkg::OP_INSERT);
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            in_reg         <= '0;
            shift_reg      <= '0;
            step_reg       <= '0;
            rem_reg        <= '0;
            issue_reg      <= '0;
            pend_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            used_reg       <= '0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_word_reg   <= '0;
            entries_reg    <= hnf_pkg::ENTRIES_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            in_reg         <= in_next;
            shift_reg      <= shift_next;
            step_reg       <= step_next;
            rem_reg        <= rem_next;
            issue_reg      <= issue_next;
            pend_idx_reg   <= pend_idx_next;
            pend_valid_reg <= pend_valid_next;
            used_reg       <= used_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            out_word_reg   <= out_word_next;
            entries_reg    <= entries_next;
        end
    end

    hnf_ram #(
        .WIDTH ($bits(hnf_pkg::entry_t)),
        .DEPTH (hnf_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pend_idx_reg),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_reg[hnf_pkg::IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // start slot from the remainder unit lies inside the live slots
    a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && $past(state_reg) == ST_DIVIDE) |-> issue_reg < live_n)
        else $error("start slot out of range");

    // at most one slot changes per item
    a_used_one_change: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(used_reg ^ $past(used_reg)) <= 1)
        else $error("more than one slot changed");

    // table writes only fill an empty slot on insert
    a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (in_reg.op == hnf_pkg::OP_INSERT) && !used_reg[pend_idx_reg])
        else $error("table write into a used slot");

    // a pending probe never points past the live slots
    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && pend_valid_reg)
        |-> hnf_pkg::CNT_W'(pend_idx_reg) < live_n)
        else $error("probe beyond live slots");

    // a full report only follows an insert
    a_status_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_reg.status) |-> in_reg.op == hnf_pkg::OP_INSERT)
        else $error("full status on a non-insert word");

endmodule

### rtl/hnf_ram.sv
module hnf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### tb/tb_hashed_netmask_filter_table.sv
`timescale 1ns / 100ps

module tb_hashed_netmask_filter_table;
    import hnf_pkg::*;

    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  DRAIN_CYCLES = 120;
    localparam int  RANDOM_ITEMS = 1800;
    localparam int  PHASES       = 8;
    localparam op_t OP_UNUSED    = op_t'(2'd3);

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg;
        in_word_t         word;
        bit               typed;
        out_word_t        result;
    } vector_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_word_t         in_word;
    logic             out_valid;
    logic             out_stall;
    out_word_t        out_word;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // shadow copy of the rule table
    logic              slot_taken [TABLE_DEPTH];
    logic [ADDR_W-1:0] slot_addr  [TABLE_DEPTH];
    logic [ADDR_W-1:0] slot_msk   [TABLE_DEPTH];
    logic [CFG_W-1:0]  slots_cfg;

    out_word_t pending_results[$];
    vector_t   directed[$];
    entry_t    rule_pool[$];
    int        mismatches     = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    hashed_netmask_filter_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic out_word_t predict_table_op(input in_word_t w);
        int unsigned live;
        int unsigned i;
        out_word_t   r;
        if (slots_cfg == 0)
            live = 1;
        else if (slots_cfg > TABLE_DEPTH)
            live = TABLE_DEPTH;
        else
            live = slots_cfg;
        r = '0;
        // probe runs from the hashed slot to the last live slot, no wrap
        case (w.op)
            OP_INSERT:
            begin
                r.status = 1'b1;
                for (i = w.address % live; i < live; i++)
                begin
                    if (!slot_taken[i])
                    begin
                        slot_taken[i] = 1'b1;
                        slot_addr[i]  = w.address;
                        slot_msk[i]   = w.mask;
                        r.status      = 1'b0;
                        break;
                    end
                end
            end
            OP_REMOVE:
            begin
                for (i = w.address % live; i < live; i++)
                begin
                    if (slot_taken[i] && slot_addr[i] == w.address && slot_msk[i] == w.mask)
                    begin
                        slot_taken[i] = 1'b0;
                        slot_addr[i]  = '0;
                        slot_msk[i]   = '0;
                        break;
                    end
                end
            end
            OP_LOOKUP:
            begin
                for (i = w.address % live; i < live; i++)
                begin
                    if (slot_taken[i] &&
                        (slot_addr[i] & slot_msk[i]) == (w.address & slot_msk[i]))
                    begin
                        r.matched = 1'b1;
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic void add_item(input op_t op, input logic [31:0] a, input logic [31:0] m,
                                     input bit typed = 1'b0, input logic st = 1'b0,
                                     input logic mt = 1'b0);
        vector_t v;
        v.is_cfg         = 1'b0;
        v.cfg            = '0;
        v.word.op        = op;
        v.word.address   = a;
        v.word.mask      = m;
        v.typed          = typed;
        v.result.status  = st;
        v.result.matched = mt;
        directed.push_back(v);
    endfunction

    function automatic void add_cfg(input logic [CFG_W-1:0] value);
        vector_t v;
        v.is_cfg = 1'b1;
        v.cfg    = value;
        v.word   = '0;
        v.typed  = 1'b0;
        v.result = '0;
        directed.push_back(v);
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        entry_t   e;
        int       pick;
        int       idx;
        int       len;
        pick      = $urandom_range(0, 99);
        w.address = $urandom;
        case ($urandom_range(0, 19))
            0: w.address = '0;
            1: w.address = '1;
            default: ;
        endcase
        len    = $urandom_range(0, 32);
        w.mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
        if ($urandom_range(0, 3) == 0)
            w.mask = $urandom;
        if (pick < 32)
        begin
            w.op = OP_INSERT;
            e.address = w.address;
            e.mask    = w.mask;
            rule_pool.push_back(e);
            if (rule_pool.size() > 160)
                void'(rule_pool.pop_front());
        end
        else if (pick < 60)
        begin
            w.op = OP_REMOVE;
            if (rule_pool.size() != 0 && $urandom_range(0, 9) < 8)
            begin
                idx       = $urandom_range(0, rule_pool.size() - 1);
                e         = rule_pool[idx];
                w.address = e.address;
                // near miss now and then: right address, one mask bit off
                if ($urandom_range(0, 9) == 0)
                    w.mask = e.mask ^ (32'h1 << $urandom_range(0, 31));
                else
                begin
                    w.mask = e.mask;
                    rule_pool.delete(idx);
                end
            end
        end
        else if (pick < 95)
        begin
            w.op = OP_LOOKUP;
            if (rule_pool.size() != 0 && $urandom_range(0, 9) < 7)
            begin
                e         = rule_pool[$urandom_range(0, rule_pool.size() - 1)];
                w.address = (e.address & e.mask) | (w.address & ~e.mask);
            end
        end
        else
            w.op = OP_UNUSED;
        return w;
    endfunction

    task automatic push_item(input in_word_t w, input bit typed, input out_word_t typed_result);
        out_word_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_table_op(w);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic write_entries(input logic [CFG_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        slots_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver side
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        out_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    note_mismatch($sformatf("word with none expected: status=%b matched=%b",
                                            out_word.status, out_word.matched));
                else
                begin
                    want = pending_results.pop_front();
                    if (out_word.status !== want.status)
                        note_mismatch($sformatf("status got %b want %b",
                                                out_word.status, want.status));
                    if (out_word.matched !== want.matched)
                        note_mismatch($sformatf("matched got %b want %b",
                                                out_word.matched, want.matched));
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] phase_cfg [PHASES];
        int               phase;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        slots_cfg = ENTRIES_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_taken[i] = 1'b0;
            slot_addr[i]  = '0;
            slot_msk[i]   = '0;
        end

        // empty table never matches
        add_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        add_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        add_item(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        add_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        add_item(OP_INSERT, 32'hC0A8_0100, 32'hFFFF_FF00, 1'b1, 1'b0, 1'b0);
        add_item(OP_LOOKUP, 32'hC0A8_01FF, 32'h0000_0000);
        add_item(OP_LOOKUP, 32'hC0A8_0100, 32'hFFFF_FFFF);
        // last slot: first insert fits, second finds no room and does not wrap
        add_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        add_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
        add_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        add_item(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        add_item(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        add_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(OP_REMOVE, 32'hC0A8_0100, 32'hFFFF_0000, 1'b1, 1'b0, 1'b0);
        add_cfg(7'd0);
        add_item(OP_INSERT, 32'h1234_5678, 32'hFFFF_0000);
        add_item(OP_LOOKUP, 32'hC0A8_0177, 32'h0000_0000);
        add_cfg(7'd1);
        add_item(OP_REMOVE, 32'hC0A8_0100, 32'hFFFF_FF00, 1'b1, 1'b0, 1'b0);
        add_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        add_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        add_item(OP_LOOKUP, 32'h89AB_CDEF, 32'h0000_0000);
        add_cfg(7'd127);
        add_item(OP_LOOKUP, 32'h0000_0040, 32'hFFFF_FFFF);
        add_item(OP_LOOKUP, 32'h0000_003F, 32'hFFFF_FFFF);
        add_cfg(7'd64);

        phase_cfg = '{7'd64, 7'd1, 7'd0, 7'd2, 7'd127, 7'd37, 7'd63, 7'd64};
        phase_cfg[5] = CFG_W'($urandom_range(3, 63));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[k])
        begin
            if (directed[k].is_cfg)
                write_entries(directed[k].cfg);
            else
                push_item(directed[k].word, directed[k].typed, directed[k].result);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            write_entries(phase_cfg[phase]);
            repeat (RANDOM_ITEMS / PHASES) push_item(random_word(), 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/hnf_pkg.sv
rtl/hnf_ram.sv
rtl/hashed_netmask_filter_table.sv
tb/tb_hashed_netmask_filter_table.sv
